// File: rtl/rcpd_pkg.sv
// shared types and constants of the radio packet channel decoder
`default_nettype none
package rcpd_pkg;

  localparam int unsigned CHANNELS        = 16;
  localparam int unsigned MAX_PACKET      = 30;
  localparam int unsigned HEADER_BYTES    = 6;
  localparam int unsigned FEWEST_CHANNELS = 4;
  localparam int unsigned COUNTER_TOP     = 31;
  localparam int unsigned MAX_REDUCTION   = CHANNELS - FEWEST_CHANNELS;

  localparam logic [11:0] MIN_RESET = 12'd1000;
  localparam logic [11:0] MAX_RESET = 12'd2000;
  localparam logic [11:0] MID_RESET = 12'd1500;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT     = 3'd1;
  localparam logic [2:0] STAT_LENGTH    = 3'd2;
  localparam logic [2:0] STAT_CHECKSUM  = 3'd3;
  localparam logic [2:0] STAT_RANGE     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN = 2'd0;
  localparam logic [1:0] CFG_MAX = 2'd1;
  localparam logic [1:0] CFG_MID = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_END_SHORT,
    ST_END_LEN,
    ST_END_SUM,
    ST_EMIT
  } state_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage
`default_nettype wire

// File: rtl/rcpd_cmp.sv
// shared magnitude and equality compare unit
`default_nettype none
module rcpd_cmp
  import rcpd_pkg::*;
(
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output cmp_res_t         res
);

  logic [16:0] diff;

  // one subtractor: borrow gives a < b, zero gives a == b
  assign diff   = {1'b0, a} - {1'b0, b};
  assign res.lt = diff[16];
  assign res.eq = (diff[15:0] == 16'd0);

endmodule
`default_nettype wire

// File: rtl/rc_packet_channel_decoder.sv
// top level of the radio packet channel decoder
`default_nettype none
// Radio packet channel decoder. Packet bytes arrive one beat at a time on
// in_packet_byte, taken when start is high and busy is low, with
// in_last_byte marking the final byte. A byte that completes a carried
// channel makes the block busy while the channel is range checked against
// channel_min and then channel_max on the one shared comparator. After
// the last byte the same comparator runs up to three end checks (short
// packet, length, checksum), one per cycle, stopping at the first that
// fails, and the block then emits either one error beat or 16 channel
// beats on consecutive cycles, one per cycle from the channel store
// through its registered read port. The block stays busy through the end
// checks and, for a good packet, through the channel beats. The error
// beat, and likewise the last channel beat, go out in the first cycle in
// which the block is ready again. Results appear on the out_ ports for
// exactly one cycle, marked by out_valid; the receiver cannot stall, so it
// must take every beat as it comes. A new packet may start while the final
// result beat is still on the outputs. Configuration must be written
// through cfg_we/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this. An index beyond the three registers is ignored.
module rc_packet_channel_decoder
  import rcpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // input beats
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_packet_byte,
  input  wire logic        in_last_byte,
  // result beats
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [3:0]       out_channel_index,
  output logic [11:0]      out_channel_value,
  output logic [4:0]       out_channel_count,
  output logic [6:0]       out_packet_mode,
  output logic [7:0]       out_model_number,
  output logic [5:0]       out_hop_channel,
  output logic             out_last_result
);

  // configuration registers
  logic [11:0] cfg_min_r, cfg_max_r, cfg_mid_r;

  // sequencer and per-packet state
  state_t      state_r, state_nxt;
  logic [4:0]  byte_cnt_r, byte_cnt_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [1:0]  phase_r, phase_nxt;   // position inside a payload triple
  logic [2:0]  pair_r, pair_nxt;     // payload triple number
  logic        fault_r, fault_nxt;
  logic [11:0] chk_val_r, chk_val_nxt;
  logic        last_r, last_nxt;
  logic [3:0]  k_r, k_nxt;           // emit channel number
  logic [4:0]  cnt_r, cnt_nxt;

  // header bytes
  logic [7:0]  hdr_r [HEADER_BYTES];
  logic        hdr_we;

  // channel store, packet order
  logic [11:0] chan_mem [CHANNELS];
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [11:0] wr_data;
  logic [3:0]  rd_addr;
  logic [11:0] rd_r;

  // emit stage
  logic        emit_v_r, emit_v_nxt;
  logic [2:0]  emit_status_r, emit_status_nxt;
  logic [3:0]  emit_idx_r, emit_idx_nxt;
  logic        emit_absent_r, emit_absent_nxt;
  logic        emit_err_r, emit_err_nxt;
  logic [4:0]  emit_count_r, emit_count_nxt;
  logic [6:0]  emit_pm_r, emit_pm_nxt;
  logic [7:0]  emit_mn_r, emit_mn_nxt;
  logic [5:0]  emit_hc_r, emit_hc_nxt;
  logic        emit_last_r, emit_last_nxt;

  // shared compare unit
  logic [15:0] cmp_a, cmp_b;
  cmp_res_t    cmp_res;

  // header derived values
  logic [3:0]  red_raw, red_c;
  logic [2:0]  red_half;
  logic [4:0]  red_cost;
  logic [4:0]  count;
  logic [4:0]  expected;

  // accept cycle helpers
  logic        in_region;
  logic [3:0]  take_k;
  logic        clear;

  rcpd_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  assign busy = (state_r != ST_IDLE);

  // channel reduction clamped, carried count and expected length
  assign red_raw  = hdr_r[2][3:0];
  assign red_c    = (red_raw > 4'(MAX_REDUCTION)) ? 4'(MAX_REDUCTION) : red_raw;
  assign red_half = red_c[3:1];
  assign red_cost = {1'b0, red_half, 1'b0} + {2'b00, red_half};
  assign count    = 5'(CHANNELS) - {1'b0, red_c};
  assign expected = 5'(MAX_PACKET) - red_cost;

  assign in_region = (byte_cnt_r >= 5'(HEADER_BYTES)) && (byte_cnt_r < 5'(MAX_PACKET));
  assign take_k    = {pair_r, (phase_r == 2'd2)};

  // standard order swaps the two channels within each of the first two pairs
  assign rd_addr = (k_r < 4'd4) ? {k_r[3:1], ~k_r[0]} : k_r;

  // operand selection for the shared comparator
  always_comb begin
    cmp_a = 16'd0;
    cmp_b = 16'd0;
    case (state_r)
      ST_CHK_LO: begin
        cmp_a = {4'd0, chk_val_r};
        cmp_b = {4'd0, cfg_min_r};
      end
      ST_CHK_HI: begin
        cmp_a = {4'd0, cfg_max_r};
        cmp_b = {4'd0, chk_val_r};
      end
      ST_END_SHORT: begin
        cmp_a = {11'd0, byte_cnt_r};
        cmp_b = 16'(HEADER_BYTES);
      end
      ST_END_LEN: begin
        cmp_a = {11'd0, byte_cnt_r};
        cmp_b = {11'd0, expected};
      end
      ST_END_SUM: begin
        cmp_a = sum_r;
        cmp_b = {hdr_r[5], hdr_r[4]};
      end
      default: begin
        cmp_a = 16'd0;
        cmp_b = 16'd0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    byte_cnt_nxt    = byte_cnt_r;
    sum_nxt         = sum_r;
    pend_nxt        = pend_r;
    phase_nxt       = phase_r;
    pair_nxt        = pair_r;
    fault_nxt       = fault_r;
    chk_val_nxt     = chk_val_r;
    last_nxt        = last_r;
    k_nxt           = k_r;
    cnt_nxt         = cnt_r;
    hdr_we          = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = take_k;
    wr_data         = 12'd0;
    clear           = 1'b0;
    emit_v_nxt      = 1'b0;
    emit_status_nxt = emit_status_r;
    emit_idx_nxt    = emit_idx_r;
    emit_absent_nxt = emit_absent_r;
    emit_err_nxt    = emit_err_r;
    emit_count_nxt  = emit_count_r;
    emit_pm_nxt     = emit_pm_r;
    emit_mn_nxt     = emit_mn_r;
    emit_hc_nxt     = emit_hc_r;
    emit_last_nxt   = emit_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          last_nxt = in_last_byte;
          hdr_we   = (byte_cnt_r < 5'(HEADER_BYTES));
          // checksum skips the top bit of byte 0 and the checksum bytes
          if (byte_cnt_r == 5'd0) begin
            sum_nxt = sum_r + {9'd0, in_packet_byte[6:0]};
          end else if (byte_cnt_r <= 5'd3 || byte_cnt_r >= 5'(HEADER_BYTES)) begin
            sum_nxt = sum_r + {8'd0, in_packet_byte};
          end
          if (byte_cnt_r < 5'(COUNTER_TOP)) begin
            byte_cnt_nxt = byte_cnt_r + 5'd1;
          end
          state_nxt = in_last_byte ? ST_END_SHORT : ST_IDLE;
          if (in_region) begin
            pend_nxt = in_packet_byte;
            if (phase_r == 2'd2) begin
              phase_nxt = 2'd0;
              pair_nxt  = pair_r + 3'd1;
            end else begin
              phase_nxt = phase_r + 2'd1;
            end
            if (phase_r != 2'd0) begin
              wr_en   = 1'b1;
              wr_data = (phase_r == 2'd1) ? {in_packet_byte[3:0], pend_r}
                                          : {in_packet_byte, pend_r[7:4]};
              chk_val_nxt = wr_data;
              // only carried channels are range checked
              if ({1'b0, take_k} < count) begin
                state_nxt = ST_CHK_LO;
              end
            end
          end
        end
      end
      ST_CHK_LO: begin
        if (cmp_res.lt) fault_nxt = 1'b1;
        state_nxt = ST_CHK_HI;
      end
      ST_CHK_HI: begin
        if (cmp_res.lt) fault_nxt = 1'b1;
        state_nxt = last_r ? ST_END_SHORT : ST_IDLE;
      end
      ST_END_SHORT: begin
        if (cmp_res.lt) begin
          emit_v_nxt      = 1'b1;
          emit_status_nxt = STAT_SHORT;
          emit_idx_nxt    = 4'd0;
          emit_err_nxt    = 1'b1;
          emit_absent_nxt = 1'b0;
          emit_count_nxt  = 5'd0;
          emit_pm_nxt     = 7'd0;
          emit_mn_nxt     = 8'd0;
          emit_hc_nxt     = 6'd0;
          emit_last_nxt   = 1'b1;
          clear           = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_END_LEN;
        end
      end
      ST_END_LEN: begin
        if (!cmp_res.eq) begin
          emit_v_nxt      = 1'b1;
          emit_status_nxt = STAT_LENGTH;
          emit_idx_nxt    = 4'd0;
          emit_err_nxt    = 1'b1;
          emit_absent_nxt = 1'b0;
          emit_count_nxt  = 5'd0;
          emit_pm_nxt     = hdr_r[0][6:0];
          emit_mn_nxt     = hdr_r[3];
          emit_hc_nxt     = hdr_r[1][5:0];
          emit_last_nxt   = 1'b1;
          clear           = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_END_SUM;
        end
      end
      ST_END_SUM: begin
        clear = 1'b1;
        k_nxt   = 4'd0;
        cnt_nxt = count;
        if (!cmp_res.eq || fault_r) begin
          emit_v_nxt      = 1'b1;
          emit_status_nxt = !cmp_res.eq ? STAT_CHECKSUM : STAT_RANGE;
          emit_idx_nxt    = 4'd0;
          emit_err_nxt    = 1'b1;
          emit_absent_nxt = 1'b0;
          emit_count_nxt  = 5'd0;
          emit_pm_nxt     = hdr_r[0][6:0];
          emit_mn_nxt     = hdr_r[3];
          emit_hc_nxt     = hdr_r[1][5:0];
          emit_last_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // read issued this cycle, data joins the emit stage next cycle
        emit_v_nxt      = 1'b1;
        emit_status_nxt = STAT_OK;
        emit_idx_nxt    = k_r;
        emit_err_nxt    = 1'b0;
        emit_absent_nxt = ({1'b0, k_r} >= cnt_r);
        emit_count_nxt  = cnt_r;
        emit_pm_nxt     = hdr_r[0][6:0];
        emit_mn_nxt     = hdr_r[3];
        emit_hc_nxt     = hdr_r[1][5:0];
        emit_last_nxt   = (k_r == 4'(CHANNELS - 1));
        k_nxt           = k_r + 4'd1;
        if (k_r == 4'(CHANNELS - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // end of packet: per-packet state back to reset
    if (clear) begin
      byte_cnt_nxt = 5'd0;
      sum_nxt      = 16'd0;
      pend_nxt     = 8'd0;
      phase_nxt    = 2'd0;
      pair_nxt     = 3'd0;
      fault_nxt    = 1'b0;
      last_nxt     = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      byte_cnt_r <= 5'd0;
      sum_r      <= 16'd0;
      pend_r     <= 8'd0;
      phase_r    <= 2'd0;
      pair_r     <= 3'd0;
      fault_r    <= 1'b0;
      last_r     <= 1'b0;
      k_r        <= 4'd0;
      cnt_r      <= 5'd0;
      emit_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      sum_r      <= sum_nxt;
      pend_r     <= pend_nxt;
      phase_r    <= phase_nxt;
      pair_r     <= pair_nxt;
      fault_r    <= fault_nxt;
      last_r     <= last_nxt;
      k_r        <= k_nxt;
      cnt_r      <= cnt_nxt;
      emit_v_r   <= emit_v_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r <= MIN_RESET;
      cfg_max_r <= MAX_RESET;
      cfg_mid_r <= MID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN: cfg_min_r <= cfg_data;
        CFG_MAX: cfg_max_r <= cfg_data;
        CFG_MID: cfg_mid_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    chk_val_r     <= chk_val_nxt;
    emit_status_r <= emit_status_nxt;
    emit_idx_r    <= emit_idx_nxt;
    emit_absent_r <= emit_absent_nxt;
    emit_err_r    <= emit_err_nxt;
    emit_count_r  <= emit_count_nxt;
    emit_pm_r     <= emit_pm_nxt;
    emit_mn_r     <= emit_mn_nxt;
    emit_hc_r     <= emit_hc_nxt;
    emit_last_r   <= emit_last_nxt;
    if (hdr_we) hdr_r[byte_cnt_r[2:0]] <= in_packet_byte;
  end

  // channel store, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) chan_mem[wr_addr] <= wr_data;
    rd_r <= chan_mem[rd_addr];
  end

  // result ports
  assign out_valid         = emit_v_r;
  assign out_status        = emit_status_r;
  assign out_channel_index = emit_idx_r;
  assign out_channel_value = emit_err_r    ? 12'd0 :
                             emit_absent_r ? cfg_mid_r : rd_r;
  assign out_channel_count = emit_count_r;
  assign out_packet_mode   = emit_pm_r;
  assign out_model_number  = emit_mn_r;
  assign out_hop_channel   = emit_hc_r;
  assign out_last_result   = emit_last_r;

  // a result beat only follows a busy cycle
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding busy cycle");

  // an error result is always the single and last beat
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> out_last_result)
    else $error("error result not marked last");

  // a good packet ends on the top standard channel
  a_ok_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result && out_status == STAT_OK)
      |-> (out_channel_index == 4'(CHANNELS - 1)))
    else $error("good packet ended early");

  // channel beats of one packet are back to back
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |=> out_valid)
    else $error("gap inside a result burst");

  // a last byte always leads into the end checks
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_byte) |=> busy)
    else $error("last byte did not start end of packet checks");

endmodule
`default_nettype wire
